// ===== rtl/rsi_pkg.sv =====
// Shared constants and types for the ray-sphere intersection pipeline.
`timescale 1ns / 1ps
package rsi_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int FRAC_BITS_DEF   = 16;
  // width of one partial-product operand in the pipelined multipliers
  localparam int MUL_CHUNK       = 32;

  typedef enum logic [1:0] {
    ST_HIT      = 2'd0,
    ST_MISS     = 2'd1,
    ST_ZERO_DIR = 2'd2
  } status_t;

  // control leaving a divider lane
  typedef struct packed {
    logic    valid;
    logic    sat;
    status_t status;
  } div_ctl_t;

endpackage

// ===== rtl/ray_sphere_intersect.sv =====
// Top level of the pipelined ray-sphere intersection block.
`timescale 1ns / 1ps
// Ray-sphere intersection, fully pipelined.
// Input beats on in_* carry a ray origin, an unnormalized direction, a sphere
// center and a radius in signed fixed point. Each beat yields one output beat
// on out_*: status (hit, miss, zero direction), the entry and exit parameters
// floor((b -/+ sqrt(disc)) * 2^FRAC_BITS / a) and a saturation flag. Miss and
// zero direction return zero parameters.
// From accept to out_tvalid a beat passes the dot products and discriminant,
// one stage per root bit of the square root, one stage per quotient bit of
// the two parallel dividers, and a two-entry output queue.
// Throughput is one beat per cycle while the queue has room; every stage then takes a new item each cycle.
// When the receiver stalls, the output queue holds up to two results and the
// whole pipeline freezes once the queue is full; nothing is dropped or repeated.
// in_tready is high while the queue has room.
// A synchronous active-low reset clears all valid bits and empties the queue.
module ray_sphere_intersect
  import rsi_pkg::*;
#(
  parameter int COORD_WIDTH = COORD_WIDTH_DEF,
  parameter int FRAC_BITS   = FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst_n,
  // start_x, start_y, start_z, dir_x, dir_y, dir_z, center_x, center_y,
  // center_z, radius (COORD_WIDTH-1 bits), zero fill
  input  logic [((10*COORD_WIDTH-1+7)/8)*8-1:0] in_tdata,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // t_near, t_far, zero fill
  output logic [((2*COORD_WIDTH+7)/8)*8-1:0]    out_tdata,
  // status (2 bits), saturated
  output logic [2:0]                            out_tuser,
  output logic                                  out_tvalid,
  input  logic                                  out_tready
);

  localparam int CW     = COORD_WIDTH;
  localparam int FB     = FRAC_BITS;
  localparam int OUT_TW = ((2*CW+7)/8)*8;
  localparam int BW2    = 2*CW + 2;   // b, signed
  localparam int CW3    = 2*CW + 3;   // c, signed
  localparam int PW4    = 4*CW + 2;   // b*b and a*|c|
  localparam int DSW    = 4*CW + 4;   // discriminant, signed
  localparam int SIN    = 4*CW - 2;   // nonnegative discriminant bits
  localparam int RW     = SIN / 2;    // root bits
  localparam int SBW    = 2 + BW2 + 2*CW;
  localparam int NW     = 2*CW + 1 + FB;

  logic en;

  // ---------------- stage A: unpack and form m = center - start
  logic [CW-1:0] st_in [3];
  logic [CW-1:0] dr_in [3];
  logic [CW-1:0] ce_in [3];
  logic [CW-2:0] rad_in;
  logic [CW-1:0] d_a_r [3];
  logic [CW:0]   m_a_r [3];
  logic [CW-2:0] r_a_r;
  logic          v_a_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      st_in[k] = in_tdata[k*CW +: CW];
      dr_in[k] = in_tdata[(3+k)*CW +: CW];
      ce_in[k] = in_tdata[(6+k)*CW +: CW];
    end
    rad_in = in_tdata[9*CW +: CW-1];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_a_r <= 1'b0;
    end else if (en) begin
      v_a_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < 3; k++) begin
        d_a_r[k] <= dr_in[k];
        m_a_r[k] <= {ce_in[k][CW-1], ce_in[k]} - {st_in[k][CW-1], st_in[k]};
      end
      r_a_r <= rad_in;
    end
  end

  // ---------------- stage B: first products on magnitudes
  logic [CW-1:0]     d_mag [3];
  logic [CW:0]       m_mag [3];
  logic [2:0]        sg_md;
  logic [2*CW-1:0]   dd_p  [3];
  logic [2*CW:0]     md_p  [3];
  logic [2*CW+1:0]   mm_p  [3];
  logic [2*CW-3:0]   rr_p;
  logic [2:0]        sg_b1_r, sg_b2_r;
  logic              v_b1_r, v_b2_r;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      d_mag[k] = d_a_r[k][CW-1] ? (~d_a_r[k] + 1'b1) : d_a_r[k];
      m_mag[k] = m_a_r[k][CW]   ? (~m_a_r[k] + 1'b1) : m_a_r[k];
      sg_md[k] = d_a_r[k][CW-1] ^ m_a_r[k][CW];
    end
  end

  for (genvar k = 0; k < 3; k++) begin : g_dot
    rsi_mul #(.AW(CW), .BW(CW)) u_dd (
      .clk(clk), .en(en), .a(d_mag[k]), .b(d_mag[k]), .p(dd_p[k])
    );
    rsi_mul #(.AW(CW+1), .BW(CW)) u_md (
      .clk(clk), .en(en), .a(m_mag[k]), .b(d_mag[k]), .p(md_p[k])
    );
    rsi_mul #(.AW(CW+1), .BW(CW+1)) u_mm (
      .clk(clk), .en(en), .a(m_mag[k]), .b(m_mag[k]), .p(mm_p[k])
    );
  end

  rsi_mul #(.AW(CW-1), .BW(CW-1)) u_rr (
    .clk(clk), .en(en), .a(r_a_r), .b(r_a_r), .p(rr_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_b1_r <= 1'b0;
      v_b2_r <= 1'b0;
    end else if (en) begin
      v_b1_r <= v_a_r;
      v_b2_r <= v_b1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sg_b1_r <= sg_md;
      sg_b2_r <= sg_b1_r;
    end
  end

  // ---------------- stage C: a = d.d, b = m.d, c = m.m - r*r
  logic [2*CW-1:0] a_nxt;
  logic [BW2-1:0]  b_nxt;
  logic [BW2-1:0]  md_t;
  logic [CW3-1:0]  c_nxt;
  logic [2*CW-1:0] a_c_r;
  logic [BW2-1:0]  b_c_r;
  logic [CW3-1:0]  c_c_r;
  logic            v_c_r;

  always_comb begin
    a_nxt = dd_p[0] + dd_p[1] + dd_p[2];
    b_nxt = '0;
    for (int k = 0; k < 3; k++) begin
      md_t  = BW2'(md_p[k]);
      b_nxt = b_nxt + (sg_b2_r[k] ? (~md_t + 1'b1) : md_t);
    end
    c_nxt = CW3'(mm_p[0]) + CW3'(mm_p[1]) + CW3'(mm_p[2]) - CW3'(rr_p);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_c_r <= 1'b0;
    end else if (en) begin
      v_c_r <= v_b2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_c_r <= a_nxt;
      b_c_r <= b_nxt;
      c_c_r <= c_nxt;
    end
  end

  // ---------------- stage D: b*b and a*c
  logic [BW2-1:0]  b_abs;
  logic [CW3-1:0]  c_abs;
  logic [PW4-1:0]  bb_p;
  logic [PW4-1:0]  ac_p;
  logic [2*CW-1:0] a_d1_r, a_d2_r;
  logic [BW2-1:0]  b_d1_r, b_d2_r;
  logic            cn_d1_r, cn_d2_r;
  logic            v_d1_r, v_d2_r;

  assign b_abs = b_c_r[BW2-1] ? (~b_c_r + 1'b1) : b_c_r;
  assign c_abs = c_c_r[CW3-1] ? (~c_c_r + 1'b1) : c_c_r;

  rsi_mul #(.AW(2*CW+1), .BW(2*CW+1)) u_bb (
    .clk(clk), .en(en), .a(b_abs[2*CW:0]), .b(b_abs[2*CW:0]), .p(bb_p)
  );
  rsi_mul #(.AW(2*CW), .BW(2*CW+2)) u_ac (
    .clk(clk), .en(en), .a(a_c_r), .b(c_abs[2*CW+1:0]), .p(ac_p)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_d1_r <= 1'b0;
      v_d2_r <= 1'b0;
    end else if (en) begin
      v_d1_r <= v_c_r;
      v_d2_r <= v_d1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_d1_r  <= a_c_r;
      a_d2_r  <= a_d1_r;
      b_d1_r  <= b_c_r;
      b_d2_r  <= b_d1_r;
      cn_d1_r <= c_c_r[CW3-1];
      cn_d2_r <= cn_d1_r;
    end
  end

  // ---------------- stage E: discriminant and status
  logic [DSW-1:0]  disc;
  status_t         st_nxt;
  logic [SIN-1:0]  disc_e_r;
  status_t         st_e_r;
  logic [2*CW-1:0] a_e_r;
  logic [BW2-1:0]  b_e_r;
  logic            v_e_r;

  always_comb begin
    disc = cn_d2_r ? (DSW'(bb_p) + DSW'(ac_p)) : (DSW'(bb_p) - DSW'(ac_p));
    if (a_d2_r == '0) begin
      st_nxt = ST_ZERO_DIR;
    end else if (disc[DSW-1]) begin
      st_nxt = ST_MISS;
    end else begin
      st_nxt = ST_HIT;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_e_r <= 1'b0;
    end else if (en) begin
      v_e_r <= v_d2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      disc_e_r <= disc[SIN-1:0];
      st_e_r   <= st_nxt;
      a_e_r    <= a_d2_r;
      b_e_r    <= b_d2_r;
    end
  end

  // ---------------- square root
  logic [RW-1:0]   sq_root;
  logic [SBW-1:0]  sq_sb;
  logic            sq_v;
  logic [2*CW-1:0] a_q;
  logic [BW2-1:0]  b_q;
  status_t         st_q;

  rsi_sqrt #(.IW(SIN), .SBW(SBW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_e_r),
    .v        (disc_e_r),
    .in_sb    ({st_e_r, b_e_r, a_e_r}),
    .out_valid(sq_v),
    .root     (sq_root),
    .out_sb   (sq_sb)
  );

  assign a_q  = sq_sb[2*CW-1:0];
  assign b_q  = sq_sb[2*CW +: BW2];
  assign st_q = status_t'(sq_sb[SBW-1 -: 2]);

  // ---------------- stage F: b - s and b + s
  logic [BW2-1:0]  sn_f_r, sf_f_r;
  logic [2*CW-1:0] a_f_r;
  status_t         st_f_r;
  logic            v_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_f_r <= 1'b0;
    end else if (en) begin
      v_f_r <= sq_v;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sn_f_r <= b_q - BW2'(sq_root);
      sf_f_r <= b_q + BW2'(sq_root);
      a_f_r  <= a_q;
      st_f_r <= st_q;
    end
  end

  // ---------------- stage G: sign and magnitude of both numerators
  logic [BW2-1:0]  sn_abs, sf_abs;
  logic [2*CW:0]   mn_g_r, mf_g_r;
  logic            nn_g_r, nf_g_r;
  logic [2*CW-1:0] a_g_r;
  status_t         st_g_r;
  logic            v_g_r;

  assign sn_abs = sn_f_r[BW2-1] ? (~sn_f_r + 1'b1) : sn_f_r;
  assign sf_abs = sf_f_r[BW2-1] ? (~sf_f_r + 1'b1) : sf_f_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_g_r <= 1'b0;
    end else if (en) begin
      v_g_r <= v_f_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mn_g_r <= sn_abs[2*CW:0];
      mf_g_r <= sf_abs[2*CW:0];
      nn_g_r <= sn_f_r[BW2-1];
      nf_g_r <= sf_f_r[BW2-1];
      a_g_r  <= a_f_r;
      st_g_r <= st_f_r;
    end
  end

  // ---------------- two divider lanes
  logic [CW-1:0] t_n, t_f;
  div_ctl_t      ctl_n, ctl_f;

  rsi_div #(.NW(NW), .DW(2*CW), .QW(CW)) u_div_near (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_g_r),
    .n_mag    ({mn_g_r, {FB{1'b0}}}),
    .neg      (nn_g_r),
    .den      (a_g_r),
    .in_status(st_g_r),
    .t        (t_n),
    .ctl      (ctl_n)
  );

  rsi_div #(.NW(NW), .DW(2*CW), .QW(CW)) u_div_far (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_valid (v_g_r),
    .n_mag    ({mf_g_r, {FB{1'b0}}}),
    .neg      (nf_g_r),
    .den      (a_g_r),
    .in_status(st_g_r),
    .t        (t_f),
    .ctl      (ctl_f)
  );

  // ---------------- result assembly and output queue
  logic              hit;
  logic              push, pop;
  logic [OUT_TW-1:0] res_data;
  logic [2:0]        res_user;
  logic [OUT_TW-1:0] q_data_r [2];
  logic [2:0]        q_user_r [2];
  logic              wp_r, rp_r;
  logic [1:0]        cnt_r;

  assign hit      = (ctl_n.status == ST_HIT);
  assign res_data = hit ? OUT_TW'({t_f, t_n}) : '0;
  assign res_user = {hit & (ctl_n.sat | ctl_f.sat), ctl_n.status};

  assign en         = (cnt_r != 2'd2);
  assign in_tready  = en;
  assign push       = en & ctl_n.valid;
  assign out_tvalid = (cnt_r != 2'd0);
  assign pop        = out_tvalid & out_tready;
  assign out_tdata  = q_data_r[rp_r];
  assign out_tuser  = q_user_r[rp_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      if (push) begin
        wp_r <= ~wp_r;
      end
      if (pop) begin
        rp_r <= ~rp_r;
      end
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_data_r[wp_r] <= res_data;
      q_user_r[wp_r] <= res_user;
    end
  end

  // ---------------- checks
  a_lanes_aligned: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl_n.valid == ctl_f.valid) && (!ctl_n.valid || ctl_n.status == ctl_f.status))
    else $error("divider lanes out of step");

  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    ctl_n.valid && !en |=> ctl_n.valid)
    else $error("result lost while queue full");

  a_stall_has_data: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> out_tvalid)
    else $error("input stalled with empty output queue");

  a_nonhit_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tuser[1:0] != ST_HIT) |-> (out_tdata == '0) && !out_tuser[2])
    else $error("non-hit result carries data");

endmodule

// ===== rtl/rsi_mul.sv =====
// Two-stage unsigned multiplier built from registered 32x32 partial products.
`timescale 1ns / 1ps
module rsi_mul
  import rsi_pkg::*;
#(
  parameter int AW = 32,
  parameter int BW = 32
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int NA = (AW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int NB = (BW + MUL_CHUNK - 1) / MUL_CHUNK;
  localparam int AP = NA * MUL_CHUNK;
  localparam int BP = NB * MUL_CHUNK;
  localparam int SW = AP + BP;
  localparam int PW = AW + BW;

  logic [AP-1:0]          a_ext;
  logic [BP-1:0]          b_ext;
  logic [2*MUL_CHUNK-1:0] pp_r [NA*NB];
  logic [SW-1:0]          sum;
  logic [PW-1:0]          p_r;

  assign a_ext = AP'(a);
  assign b_ext = BP'(b);

  // form every chunk product
  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < NA; i++) begin
        for (int j = 0; j < NB; j++) begin
          pp_r[i*NB+j] <= a_ext[i*MUL_CHUNK +: MUL_CHUNK] * b_ext[j*MUL_CHUNK +: MUL_CHUNK];
        end
      end
    end
  end

  // align and add the partial products
  always_comb begin
    sum = '0;
    for (int i = 0; i < NA; i++) begin
      for (int j = 0; j < NB; j++) begin
        sum = sum + (SW'(pp_r[i*NB+j]) << (MUL_CHUNK * (i + j)));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p_r <= sum[PW-1:0];
    end
  end

  assign p = p_r;

endmodule

// ===== rtl/rsi_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
`timescale 1ns / 1ps
module rsi_sqrt #(
  parameter int IW  = 126,
  parameter int SBW = 8
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            en,
  input  logic            in_valid,
  input  logic [IW-1:0]   v,
  input  logic [SBW-1:0]  in_sb,
  output logic            out_valid,
  output logic [IW/2-1:0] root,
  output logic [SBW-1:0]  out_sb
);

  localparam int RW   = IW / 2;
  localparam int REMW = RW + 2;

  logic [IW-1:0]   rest_r [RW];
  logic [REMW-1:0] rem_r  [RW];
  logic [RW-1:0]   root_r [RW+1];
  logic [SBW-1:0]  sb_r   [RW+1];
  logic            vld_r  [RW+1];

  // load stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rest_r[0] <= v;
      rem_r[0]  <= '0;
      root_r[0] <= '0;
      sb_r[0]   <= in_sb;
    end
  end

  // one root bit per stage: bring down two radicand bits, try (root*4+1)
  for (genvar s = 1; s <= RW; s++) begin : g_stage
    logic [REMW-1:0] rem_sh;
    logic [REMW-1:0] trial;
    logic            ge;

    assign rem_sh = {rem_r[s-1][REMW-3:0], rest_r[s-1][IW-1 -: 2]};
    assign trial  = {root_r[s-1], 2'b01};
    assign ge     = (rem_sh >= trial);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        root_r[s] <= {root_r[s-1][RW-2:0], ge};
        sb_r[s]   <= sb_r[s-1];
      end
    end

    if (s < RW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s]  <= ge ? (rem_sh - trial) : rem_sh;
          rest_r[s] <= rest_r[s-1] << 2;
        end
      end
    end
  end

  assign out_valid = vld_r[RW];
  assign root      = root_r[RW];
  assign out_sb    = sb_r[RW];

endmodule

// ===== rtl/rsi_div.sv =====
// Pipelined floor division of a signed magnitude by an unsigned divisor, with clamp.
`timescale 1ns / 1ps
module rsi_div
  import rsi_pkg::*;
#(
  parameter int NW = 81,
  parameter int DW = 64,
  parameter int QW = 32
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  logic [NW-1:0] n_mag,
  input  logic          neg,
  input  logic [DW-1:0] den,
  input  status_t       in_status,
  output logic [QW-1:0] t,
  output div_ctl_t      ctl
);

  localparam int XW = (NW > DW + QW) ? NW : DW + QW;
  localparam logic [QW:0]   HALF   = (QW+1)'(1) << (QW - 1);
  localparam logic [QW-1:0] MAX_T  = {1'b0, {(QW-1){1'b1}}};
  localparam logic [QW-1:0] MIN_T  = {1'b1, {(QW-1){1'b0}}};

  logic [XW-1:0] rem_r [QW+1];
  logic [QW-1:0] q_r   [QW+1];
  logic [DW-1:0] den_r [QW];
  logic          neg_r [QW+1];
  logic          ovf_r [QW+1];
  status_t       st_r  [QW+1];
  logic          vld_r [QW+1];

  logic          ovf0;
  logic          rem_nz;
  logic [QW:0]   mag;
  logic [QW:0]   mag_neg;
  logic          sat_nxt;
  logic [QW-1:0] t_nxt;
  logic [QW-1:0] t_r;
  logic          sat_r;
  status_t       st_out_r;
  logic          vld_out_r;

  // load stage: flag a quotient that does not fit QW bits
  assign ovf0 = (XW'(n_mag) >= (XW'(den) << QW));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= XW'(n_mag);
      q_r[0]   <= '0;
      den_r[0] <= den;
      neg_r[0] <= neg;
      ovf_r[0] <= ovf0;
      st_r[0]  <= in_status;
    end
  end

  // restoring division, most significant quotient bit first
  for (genvar s = 1; s <= QW; s++) begin : g_stage
    localparam int K = QW - s;
    logic [XW-1:0] dsh;
    logic          ge;

    assign dsh = XW'(den_r[s-1]) << K;
    assign ge  = (rem_r[s-1] >= dsh);

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else if (en) begin
        vld_r[s] <= vld_r[s-1];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[s] <= ge ? (rem_r[s-1] - dsh) : rem_r[s-1];
        q_r[s]   <= q_r[s-1] | (QW'(ge) << K);
        neg_r[s] <= neg_r[s-1];
        ovf_r[s] <= ovf_r[s-1];
        st_r[s]  <= st_r[s-1];
      end
    end

    if (s < QW) begin : g_den
      always_ff @(posedge clk) begin
        if (en) begin
          den_r[s] <= den_r[s-1];
        end
      end
    end
  end

  // round toward minus infinity, negate, clamp
  always_comb begin
    rem_nz  = (rem_r[QW] != '0);
    mag     = {1'b0, q_r[QW]} + (QW+1)'(rem_nz);
    mag_neg = ~mag + 1'b1;
    if (neg_r[QW]) begin
      sat_nxt = ovf_r[QW] || (mag > HALF);
      t_nxt   = sat_nxt ? MIN_T : mag_neg[QW-1:0];
    end else begin
      sat_nxt = ovf_r[QW] || q_r[QW][QW-1];
      t_nxt   = sat_nxt ? MAX_T : q_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_out_r <= 1'b0;
    end else if (en) begin
      vld_out_r <= vld_r[QW];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t_r      <= t_nxt;
      sat_r    <= sat_nxt;
      st_out_r <= st_r[QW];
    end
  end

  assign t          = t_r;
  assign ctl.valid  = vld_out_r;
  assign ctl.sat    = sat_r;
  assign ctl.status = st_out_r;

endmodule
